// ===== hw/rtl/kcm_pkg.sv =====
// kcm_pkg: shared constants, types and the keyword table for keyword_count_matcher.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package kcm_pkg;

   localparam int NUM_KEYWORDS = 11;
   localparam int MAX_WORD_LEN = 128;
   localparam int COUNT_WIDTH  = 32;

   localparam int TABLE_SIZE = 11;
   localparam int KW_USED    = (NUM_KEYWORDS < TABLE_SIZE) ? NUM_KEYWORDS : TABLE_SIZE;

   localparam int CHAR_W     = 8;
   localparam int PREFIX_LEN = 8;
   localparam int PREFIX_W   = CHAR_W * PREFIX_LEN;
   localparam int LEN_W      = 8;
   localparam int KW_IDX_W   = 4;
   localparam int OUT_CNT_W  = 32;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_REPORT
   } kcm_state_type;

   // finished word, broadcast to every cell
   typedef struct packed {
      logic                valid;
      logic [PREFIX_W-1:0] prefix;
      logic [LEN_W-1:0]    length;
   } kcm_word_type;

   // control toward the cell row
   typedef struct packed {
      kcm_word_type word;
      logic         shift;
   } kcm_cell_ctl_type;

   // keyword text, byte i in bits 8i+7:8i
   function automatic logic [PREFIX_W-1:0] kw_prefix(input logic [KW_IDX_W-1:0] idx);
      logic [PREFIX_W-1:0] v;
      begin
         case (idx)
            4'd0:    v = 64'h0000_0000_6f74_7561;  // auto
            4'd1:    v = 64'h0000_006b_6165_7262;  // break
            4'd2:    v = 64'h0000_0000_6573_6163;  // case
            4'd3:    v = 64'h0000_0000_7261_6863;  // char
            4'd4:    v = 64'h0000_0074_736e_6f63;  // const
            4'd5:    v = 64'h6575_6e69_746e_6f63;  // continue
            4'd6:    v = 64'h0074_6c75_6166_6564;  // default
            4'd7:    v = 64'h6465_6e67_6973_6e75;  // unsigned
            4'd8:    v = 64'h0000_0000_6469_6f76;  // void
            4'd9:    v = 64'h656c_6974_616c_6f76;  // volatile
            4'd10:   v = 64'h0000_0065_6c69_6877;  // while
            default: v = '0;
         endcase
         return v;
      end
   endfunction

   function automatic logic [LEN_W-1:0] kw_length(input logic [KW_IDX_W-1:0] idx);
      logic [LEN_W-1:0] n;
      begin
         case (idx)
            4'd0, 4'd2, 4'd3, 4'd8: n = 8'd4;
            4'd1, 4'd4, 4'd10:      n = 8'd5;
            4'd6:                   n = 8'd7;
            4'd5, 4'd7, 4'd9:       n = 8'd8;
            default:                n = '0;
         endcase
         return n;
      end
   endfunction

endpackage

// ===== hw/rtl/kcm_stream_if.sv =====
// kcm_stream_if: valid/ready channels for text bytes in and keyword counts out.
// Depends on kcm_pkg for field widths.
`timescale 1ns / 1ps

interface kcm_req_if import kcm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface kcm_rsp_if import kcm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KW_IDX_W-1:0]  keyword_index;
   logic [OUT_CNT_W-1:0] keyword_count;
   logic                 last_count;

   modport source (output valid, output keyword_index, output keyword_count,
                   output last_count, input ready);
   modport sink   (input valid, input keyword_index, input keyword_count,
                   input last_count, output ready);
endinterface

// ===== hw/rtl/kcm_tokenizer.sv =====
// kcm_tokenizer: splits the byte stream into words and emits each finished word.
// Depends on kcm_pkg.
`timescale 1ns / 1ps

module kcm_tokenizer import kcm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [CHAR_W-1:0] char_code,
   input  logic              end_of_text,
   output kcm_word_type      word
);

   logic [PREFIX_W-1:0] prefix_ff, prefix_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                in_word_ff, in_word_in;
   kcm_word_type        word_ff, word_in;

   logic                is_letter, is_alnum;
   logic [PREFIX_W-1:0] grown_prefix;
   logic [LEN_W-1:0]    grown_len;

   always_comb begin
      is_letter = (char_code inside {[8'h41:8'h5a], [8'h61:8'h7a]});
      is_alnum  = is_letter || (char_code inside {[8'h30:8'h39]});
   end

   // append the byte; only the first bytes of a word are kept
   always_comb begin
      grown_prefix = prefix_ff;
      for (int i = 0; i < PREFIX_LEN; i++) begin
         if (len_ff == LEN_W'(i)) begin
            grown_prefix[CHAR_W*i +: CHAR_W] = char_code;
         end
      end
      grown_len = len_ff + 1'b1;
   end

   always_comb begin
      prefix_in   = prefix_ff;
      len_in      = len_ff;
      in_word_in  = in_word_ff;
      word_in     = '0;
      if (take) begin
         if (end_of_text) begin
            word_in    = '{valid: in_word_ff, prefix: prefix_ff, length: len_ff};
            in_word_in = 1'b0;
            prefix_in  = '0;
            len_in     = '0;
         end else if (in_word_ff) begin
            if (!is_alnum) begin
               word_in    = '{valid: 1'b1, prefix: prefix_ff, length: len_ff};
               in_word_in = 1'b0;
               prefix_in  = '0;
               len_in     = '0;
            end else if (grown_len >= LEN_W'(MAX_WORD_LEN)) begin
               word_in    = '{valid: 1'b1, prefix: grown_prefix, length: grown_len};
               in_word_in = 1'b0;
               prefix_in  = '0;
               len_in     = '0;
            end else begin
               prefix_in = grown_prefix;
               len_in    = grown_len;
            end
         end else if (is_letter) begin
            in_word_in = 1'b1;
            prefix_in  = PREFIX_W'(char_code);
            len_in     = LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         len_ff     <= '0;
         prefix_ff  <= '0;
         word_ff    <= '0;
      end else begin
         in_word_ff <= in_word_in;
         len_ff     <= len_in;
         prefix_ff  <= prefix_in;
         word_ff    <= word_in;
      end
   end

   assign word = word_ff;

endmodule

// ===== hw/rtl/kcm_cell.sv =====
// kcm_cell: one keyword of the table with its saturating counter; counts shift
// toward cell 0 during a report. Depends on kcm_pkg.
`timescale 1ns / 1ps

module kcm_cell import kcm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [KW_IDX_W-1:0]    cell_idx,
   input  kcm_cell_ctl_type       ctl,
   input  logic [COUNT_WIDTH-1:0] count_from_next,
   output logic [COUNT_WIDTH-1:0] count
);

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   hit;

   assign hit = ctl.word.valid
             && (ctl.word.length == kw_length(cell_idx))
             && (ctl.word.prefix == kw_prefix(cell_idx));

   always_comb begin
      count_in = count_ff;
      if (ctl.shift) begin
         count_in = count_from_next;
      end else if (hit && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// ===== hw/rtl/keyword_count_matcher.sv =====
// keyword_count_matcher: counts C keywords in a byte stream (top level).
// Depends on kcm_pkg, kcm_stream_if, kcm_tokenizer and kcm_cell.
`timescale 1ns / 1ps

// Feed text one byte per beat on req_bus; a text byte is taken every cycle while
// req_bus.ready is high and yields no result. Words (a letter, then letters or
// digits) are closed by any other byte, by reaching the maximum word length, or
// by end of text. Each closed word is registered, then goes to a row of 11 cells,
// one per keyword, that compare it in parallel and bump a saturating count. A
// beat with end_of_text set closes any open word, then after the ST_FLUSH
// settling state the counts are read out in table order on rsp_bus, last one
// flagged by last_count. The readout shifts every count one cell toward cell 0
// per result beat, so the counts come out in order and the row is left cleared.
// req_bus.ready drops from the end-of-text beat until the last count is loaded
// into the output register, a span that each rsp_bus stall makes longer. The
// output register lets the next text byte enter while the final count still
// waits to be taken.
module keyword_count_matcher import kcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   kcm_req_if.sink     req_bus,
   kcm_rsp_if.source   rsp_bus
);

   kcm_state_type state_ff, state_in;

   logic                   req_take;
   kcm_word_type           word;
   kcm_cell_ctl_type       cell_ctl;
   logic [COUNT_WIDTH-1:0] cell_count [KW_USED];

   logic [KW_IDX_W-1:0]    rpt_idx_ff, rpt_idx_in;
   logic                   load;
   logic                   last_load;

   logic                   out_valid_ff, out_valid_in;
   logic [KW_IDX_W-1:0]    out_idx_ff, out_idx_in;
   logic [OUT_CNT_W-1:0]   out_count_ff, out_count_in;
   logic                   out_last_ff, out_last_in;

   assign req_take = req_bus.valid && req_bus.ready;

   // ---- word splitting
   kcm_tokenizer u_tokenizer (
      .clock       (clock),
      .reset       (reset),
      .take        (req_take),
      .char_code   (req_bus.char_code),
      .end_of_text (req_bus.end_of_text),
      .word        (word)
   );

   // ---- row of keyword cells; counts move toward cell 0 on a report beat
   assign cell_ctl = '{word: word, shift: load};

   for (genvar k = 0; k < KW_USED; k++) begin : g_cell
      logic [COUNT_WIDTH-1:0] next_count;
      if (k == KW_USED - 1) begin : g_tail
         assign next_count = '0;
      end else begin : g_link
         assign next_count = cell_count[k+1];
      end
      kcm_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .cell_idx        (KW_IDX_W'(k)),
         .ctl             (cell_ctl),
         .count_from_next (next_count),
         .count           (cell_count[k])
      );
   end

   // ---- report sequencer
   assign last_load = (rpt_idx_ff == KW_IDX_W'(KW_USED - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_bus.end_of_text) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // closing word is counted at the end of this cycle
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (load && last_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      load          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_FLUSH: begin
            load = 1'b0;
         end
         ST_REPORT: begin
            load = !out_valid_ff || rsp_bus.ready;
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   always_comb begin
      rpt_idx_in = rpt_idx_ff;
      if (state_ff == ST_FLUSH) begin
         rpt_idx_in = '0;
      end else if (load) begin
         rpt_idx_in = rpt_idx_ff + 1'b1;
      end
   end

   // ---- output register: hold until taken, refill on a report beat
   always_comb begin
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;
      if (rsp_bus.valid && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         out_idx_in   = rpt_idx_ff;
         out_count_in = OUT_CNT_W'(cell_count[0]);
         out_last_in  = last_load;
      end
   end

   always_ff @(posedge clock) begin
      out_idx_ff   <= out_idx_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rpt_idx_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rpt_idx_ff   <= rpt_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.keyword_index = out_idx_ff;
   assign rsp_bus.keyword_count = out_count_ff;
   assign rsp_bus.last_count    = out_last_ff;

   // ---- checks
   // a report shift must never coincide with a word being counted
   a_no_count_during_shift: assert property (@(posedge clock) disable iff (reset)
      !(cell_ctl.shift && cell_ctl.word.valid))
      else $error("word counted during report shift");

   // the flagged beat carries the last table entry
   a_last_is_final_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.last_count) |->
         (rsp_bus.keyword_index == KW_IDX_W'(KW_USED - 1)))
      else $error("last_count on wrong keyword index");

   // end of text starts the flush
   a_eot_flush: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_bus.end_of_text) |=> (state_ff == ST_FLUSH))
      else $error("end of text did not start a report");

   // report index stays within the table
   a_report_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |-> (rpt_idx_ff < KW_IDX_W'(KW_USED)))
      else $error("report index out of range");

endmodule
